// ----- rtl/auto_baud_detector_defines.svh -----
// ----------------------------------------------------------------------------
// auto baud detector assertion macros
// concurrent checks on clk with synchronous active-low reset rst_n
// ----------------------------------------------------------------------------
`ifndef AUTO_BAUD_DETECTOR_DEFINES_SVH
`define AUTO_BAUD_DETECTOR_DEFINES_SVH

`ifndef NO_ASSERTIONS
// condition holds at every edge outside reset
`define ABD_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("abd check failed");
// antecedent implies consequent in the same cycle
`define ABD_ASSERT_IMPLIES(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("abd check failed");
`else
`define ABD_ASSERT_ALWAYS(lbl, cond)
`define ABD_ASSERT_IMPLIES(lbl, pre, post)
`endif

`endif

// ----- rtl/abd_pkg.sv -----
// ----------------------------------------------------------------------------
// abd_pkg
// shared types and constants of the auto baud detector
// ----------------------------------------------------------------------------
`default_nettype none

package abd_pkg;

  localparam int CountWidth = 32;
  localparam int PulseWidth = 16;
  localparam logic [PulseWidth-1:0] IdlePulse = 16'hFFFF;

  localparam logic [1:0] CmdWidth  = 2'd0;
  localparam logic [1:0] CmdPeriod = 2'd1;
  localparam logic [1:0] CmdReport = 2'd2;

  localparam logic [2:0] StatStd   = 3'd0;
  localparam logic [2:0] StatRaw   = 3'd1;
  localparam logic [2:0] StatBelow = 3'd2;
  localparam logic [2:0] StatAbove = 3'd3;
  localparam logic [2:0] StatZero  = 3'd4;

  localparam logic [31:0] ClockHzReset = 32'd10000000;

  localparam int NumRates = 12;
  localparam logic [31:0] StdRates [NumRates] = '{
    32'd150, 32'd300, 32'd600, 32'd1200, 32'd2400, 32'd4800,
    32'd9600, 32'd19200, 32'd38400, 32'd57600, 32'd115200, 32'd230400
  };

  // scaled estimate widths: b*109 and b*100 of a 32-bit quotient
  localparam int ScaledWidth = 39;
  // floor(b*109/100) < 150  <=>  b*109 < 15000
  localparam logic [ScaledWidth-1:0] BelowLimit = 39'd15000;
  // floor(b*100/109) > 230400  <=>  b*100 >= 109*230401
  localparam logic [ScaledWidth-1:0] AboveLimit = 39'd25113709;

  localparam int QDepth = 2;
  localparam int QAw    = $clog2(QDepth);

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] capture_count;
  } in_item_t;

  typedef struct packed {
    logic [31:0] baud;
    logic [2:0]  status;
  } out_item_t;

  // push side of the pulse queue
  typedef struct packed {
    logic                  vld;
    logic [PulseWidth-1:0] pulse;
  } q_push_t;

  // queue fill status
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

`default_nettype wire

// ----- rtl/auto_baud_detector.sv -----
// ----------------------------------------------------------------------------
// auto_baud_detector
// baud rate estimate from the shortest pulse seen in timer captures
// ----------------------------------------------------------------------------
// report path: a report with a pending pulse is queued, then loaded, divided in 32
//   steps, scaled and snapped into the output register once the back end is idle
// throughput: captures and reports transfer one a cycle while the 2-entry queue
//   has room; the serial back end takes the next report only after the last is snapped
// reset: synchronous active low; clock_hz back to 10 MHz, last width 0,
//   shortest pulse rearmed to 65535, queue and result register emptied
`default_nettype none

`include "auto_baud_detector_defines.svh"

module auto_baud_detector (
  input  wire                 clk,
  input  wire                 rst_n,
  // capture and report items
  input  wire                 in_valid,
  output logic                in_stall,
  input  abd_pkg::in_item_t   in_item,
  // reported rates
  output logic                out_valid,
  input  wire                 out_stall,
  output abd_pkg::out_item_t  out_item,
  // clock_hz register write
  input  wire                 cfg_valid,
  output logic                cfg_ready,
  input  wire [31:0]          cfg_data
);

  // timer clock frequency, the dividend of every estimate
  logic [31:0] clock_hz_r, clock_hz_nxt;

  abd_pkg::q_push_t               q_push;
  abd_pkg::q_stat_t               q_stat;
  logic [abd_pkg::PulseWidth-1:0] q_head;
  logic                           q_pop;

  // register writes are always accepted and registered into clock_hz_r
  assign cfg_ready    = 1'b1;
  assign clock_hz_nxt = (cfg_valid && cfg_ready) ? cfg_data : clock_hz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clock_hz_r <= abd_pkg::ClockHzReset;
    end else begin
      clock_hz_r <= clock_hz_nxt;
    end
  end

  // front end: width/period tracking, report transfers queue the pulse
  abd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .q_stat   (q_stat),
    .q_push   (q_push)
  );

  // pending reports, lets captures keep flowing during a division
  abd_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .pop   (q_pop),
    .head  (q_head),
    .stat  (q_stat)
  );

  // back end: serial divide, scale, snap, output register
  abd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .clock_hz  (clock_hz_r),
    .q_stat    (q_stat),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  // the front end never writes into a full queue
  `ABD_ASSERT_IMPLIES(a_no_overflow, q_push.vld, !q_stat.full)
  // the back end never reads an empty queue
  `ABD_ASSERT_IMPLIES(a_no_underflow, q_pop, !q_stat.empty)
  // out of range and zero cases carry their fixed rate value
  `ABD_ASSERT_IMPLIES(a_above_ones, out_valid && out_item.status == abd_pkg::StatAbove, out_item.baud == 32'hFFFF_FFFF)
  `ABD_ASSERT_IMPLIES(a_low_zero, out_valid && (out_item.status == abd_pkg::StatBelow || out_item.status == abd_pkg::StatZero), out_item.baud == 32'd0)
  // a snapped rate lies within the standard table span
  `ABD_ASSERT_IMPLIES(a_std_span, out_valid && out_item.status == abd_pkg::StatStd, out_item.baud >= 32'd150 && out_item.baud <= 32'd230400)

endmodule

`default_nettype wire

// ----- rtl/abd_fifo.sv -----
// ----------------------------------------------------------------------------
// abd_fifo
// short queue of pending pulse lengths between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module abd_fifo (
  input  wire                            clk,
  input  wire                            rst_n,
  input  abd_pkg::q_push_t               push,
  input  wire                            pop,
  output logic [abd_pkg::PulseWidth-1:0] head,
  output abd_pkg::q_stat_t               stat
);

  logic [abd_pkg::PulseWidth-1:0] ent_r [abd_pkg::QDepth];
  logic [abd_pkg::QAw-1:0]        wp_r, wp_nxt;
  logic [abd_pkg::QAw-1:0]        rp_r, rp_nxt;
  logic [abd_pkg::QAw:0]          cnt_r, cnt_nxt;

  assign head       = ent_r[rp_r];
  assign stat.full  = (cnt_r == (abd_pkg::QAw+1)'(abd_pkg::QDepth));
  assign stat.empty = (cnt_r == '0);

  always_comb begin
    wp_nxt  = push.vld ? wp_r + 1'b1 : wp_r;
    rp_nxt  = pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r;
    if (push.vld && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push.vld) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.vld) begin
      ent_r[wp_r] <= push.pulse;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/abd_front.sv -----
// ----------------------------------------------------------------------------
// abd_front
// takes capture and report items, tracks the shortest pulse, queues reports
// ----------------------------------------------------------------------------
`default_nettype none

module abd_front (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_stall,
  input  abd_pkg::in_item_t  in_item,
  input  abd_pkg::q_stat_t   q_stat,
  output abd_pkg::q_push_t   q_push
);

  logic [abd_pkg::CountWidth-1:0] last_w_r, last_w_nxt;
  logic [abd_pkg::PulseWidth-1:0] min_r, min_nxt;
  logic [abd_pkg::CountWidth-1:0] cnt;
  logic [abd_pkg::CountWidth-1:0] pulse;
  logic                           accept;

  assign in_stall = q_stat.full;
  assign accept   = in_valid && !in_stall;
  assign cnt      = in_item.capture_count[abd_pkg::CountWidth-1:0];
  assign pulse    = cnt - last_w_r;

  assign q_push.vld   = accept && (in_item.cmd == abd_pkg::CmdReport) &&
                        (min_r != abd_pkg::IdlePulse);
  assign q_push.pulse = min_r;

  always_comb begin
    last_w_nxt = last_w_r;
    min_nxt    = min_r;
    if (accept) begin
      case (in_item.cmd)
        abd_pkg::CmdWidth: begin
          last_w_nxt = cnt;
        end
        abd_pkg::CmdPeriod: begin
          // min never exceeds the idle value, so a smaller pulse fits 16 bits
          if (pulse < abd_pkg::CountWidth'(min_r)) begin
            min_nxt = pulse[abd_pkg::PulseWidth-1:0];
          end
        end
        abd_pkg::CmdReport: begin
          min_nxt = abd_pkg::IdlePulse;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_w_r <= '0;
      min_r    <= abd_pkg::IdlePulse;
    end else begin
      last_w_r <= last_w_nxt;
      min_r    <= min_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/abd_back.sv -----
// ----------------------------------------------------------------------------
// abd_back
// divides the clock by the pulse bit by bit, scales, and classifies the result,
// snapping it to a standard rate where one fits
`default_nettype none

module abd_back (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire [31:0]                     clock_hz,
  input  abd_pkg::q_stat_t               q_stat,
  input  wire [abd_pkg::PulseWidth-1:0]  q_head,
  output logic                           q_pop,
  output logic                           out_valid,
  input  wire                            out_stall,
  output abd_pkg::out_item_t             out_item
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StDiv  = 2'd1;
  localparam logic [1:0] StMul  = 2'd2;
  localparam logic [1:0] StCmp  = 2'd3;

  logic [1:0]                       st_r, st_nxt;
  logic [4:0]                       step_r, step_nxt;
  logic [abd_pkg::PulseWidth-1:0]   div_r, div_nxt;
  logic [abd_pkg::PulseWidth-1:0]   rem_r, rem_nxt;
  logic [31:0]                      dq_r, dq_nxt;
  logic                             zero_r, zero_nxt;
  logic [abd_pkg::ScaledWidth-1:0]  b109_r, b109_nxt;
  logic [abd_pkg::ScaledWidth-1:0]  b100_r, b100_nxt;
  logic                             out_valid_r, out_valid_nxt;
  abd_pkg::out_item_t               out_r, out_nxt;

  logic [abd_pkg::PulseWidth:0]     shifted;
  logic                             ge;
  logic [abd_pkg::PulseWidth:0]     diff;
  abd_pkg::out_item_t               res;
  logic                             found;
  logic                             slot_free;

  assign out_valid = out_valid_r;
  assign out_item  = out_r;
  assign slot_free = !out_valid_r || !out_stall;
  assign q_pop     = (st_r == StIdle) && !q_stat.empty;

  // one restoring division step
  assign shifted = {rem_r, dq_r[31]};
  assign ge      = (shifted >= {1'b0, div_r});
  assign diff    = shifted - {1'b0, div_r};

  // classification of the scaled estimate
  always_comb begin
    found = 1'b0;
    res   = '{baud: dq_r, status: abd_pkg::StatRaw};
    if (zero_r) begin
      res = '{baud: 32'd0, status: abd_pkg::StatZero};
    end else if (b109_r < abd_pkg::BelowLimit) begin
      res = '{baud: 32'd0, status: abd_pkg::StatBelow};
    end else if (b100_r >= abd_pkg::AboveLimit) begin
      res = '{baud: 32'hFFFF_FFFF, status: abd_pkg::StatAbove};
    end else begin
      for (int k = 0; k < abd_pkg::NumRates; k++) begin
        // rate strictly inside the window of the estimate
        if (!found &&
            (b109_r >= abd_pkg::ScaledWidth'(64'd100 * (64'(abd_pkg::StdRates[k]) + 64'd1))) &&
            (b100_r <  abd_pkg::ScaledWidth'(64'd109 * 64'(abd_pkg::StdRates[k])))) begin
          found = 1'b1;
          res   = '{baud: abd_pkg::StdRates[k], status: abd_pkg::StatStd};
        end
      end
    end
  end

  always_comb begin
    st_nxt        = st_r;
    step_nxt      = step_r;
    div_nxt       = div_r;
    rem_nxt       = rem_r;
    dq_nxt        = dq_r;
    zero_nxt      = zero_r;
    b109_nxt      = b109_r;
    b100_nxt      = b100_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;
    case (st_r)
      StIdle: begin
        if (!q_stat.empty) begin
          div_nxt  = q_head;
          rem_nxt  = '0;
          dq_nxt   = clock_hz;
          step_nxt = '0;
          zero_nxt = (q_head == '0);
          st_nxt   = (q_head == '0) ? StCmp : StDiv;
        end
      end
      StDiv: begin
        rem_nxt  = ge ? diff[abd_pkg::PulseWidth-1:0] : shifted[abd_pkg::PulseWidth-1:0];
        dq_nxt   = {dq_r[30:0], ge};
        step_nxt = step_r + 1'b1;
        if (step_r == 5'd31) begin
          st_nxt = StMul;
        end
      end
      StMul: begin
        b109_nxt = abd_pkg::ScaledWidth'(dq_r) * abd_pkg::ScaledWidth'(109);
        b100_nxt = abd_pkg::ScaledWidth'(dq_r) * abd_pkg::ScaledWidth'(100);
        st_nxt   = StCmp;
      end
      StCmp: begin
        if (slot_free) begin
          out_nxt       = res;
          out_valid_nxt = 1'b1;
          st_nxt        = StIdle;
        end
      end
      default: begin
        st_nxt = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= StIdle;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r <= step_nxt;
    div_r  <= div_nxt;
    rem_r  <= rem_nxt;
    dq_r   <= dq_nxt;
    zero_r <= zero_nxt;
    b109_r <= b109_nxt;
    b100_r <= b100_nxt;
    out_r  <= out_nxt;
  end

endmodule

`default_nettype wire
